@@ design/afsm_pkg.sv @@
// Shared constants, field widths and record types of the frame sequencer and mixer.
package afsm_pkg;

    // Default machine clock rate in hertz.
    localparam int unsigned DEFAULT_CLOCK_HZ = 4194304;

    // Sample rate register width and its value after reset.
    localparam int unsigned RATE_W            = 17;
    localparam logic [RATE_W-1:0] RATE_RESET  = 17'd44100;

    // Channel count and field widths.
    localparam int unsigned NUM_CH   = 4;
    localparam int unsigned AMP_W    = 4;
    localparam int unsigned VOL_W    = 3;
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned SEQ_W    = 3;

    // Sequencer count that fires the envelope clock.
    localparam logic [SEQ_W-1:0] SEQ_ENV_COUNT = 3'd7;
    // Count pattern in the low two bits that fires the sweep clock.
    localparam logic [1:0] SEQ_SWEEP_PHASE = 2'b10;

    // DAC offset: four channels at 7.5 each, doubled.
    localparam logic signed [7:0] MIX_OFFSET = 8'sd60;

    // Byte-padded stream widths.
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_PAD_W   = M_TDATA_W - 5 - 2 * SAMPLE_W;

    // Strobes and sample flag from the sequencer to the merging stage.
    typedef struct packed {
        logic sample_valid;
        logic extra_length_flag;
        logic envelope_clock;
        logic sweep_clock;
        logic length_clock;
    } seq_out_t;

    // One result item, laid out as it travels on the output stream.
    typedef struct packed {
        logic [M_PAD_W-1:0]         pad;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic signed [SAMPLE_W-1:0] left_sample;
        seq_out_t                   seq;
    } result_t;

endpackage

@@ design/afsm_seq.sv @@
// Frame sequencer, sample-rate accumulator and sample rate register.
module afsm_seq import afsm_pkg::*; #(
    parameter int unsigned CLOCK_HZ = DEFAULT_CLOCK_HZ
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [RATE_W-1:0] cfg_wr_data,
    input  logic              step,
    input  logic              div_bit,
    input  logic              power,
    output seq_out_t          seq_out
);

    localparam int unsigned ACC_W = $clog2(CLOCK_HZ + (1 << RATE_W));
    localparam logic [ACC_W-1:0] THRESH = ACC_W'(CLOCK_HZ);

    logic [RATE_W-1:0] sample_rate_reg;
    logic              prev_div_reg, prev_div_next;
    logic [SEQ_W-1:0]  count_reg, count_next;
    logic              extra_reg, extra_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic [SEQ_W-1:0]  count_inc;
    logic [ACC_W-1:0]  acc_sum;
    logic              tick;
    logic              hit;

    // A falling edge of divider bit 4 while powered advances the sequencer.
    always_comb begin
        count_inc = count_reg + SEQ_W'(1);
        tick      = power & prev_div_reg & ~div_bit;
        acc_sum   = acc_reg + ACC_W'(sample_rate_reg);
        hit       = acc_sum >= THRESH;
    end

    // Strobes are decoded from the advanced count.
    always_comb begin
        seq_out.length_clock      = tick & ~count_inc[0];
        seq_out.sweep_clock       = tick & (count_inc[1:0] == SEQ_SWEEP_PHASE);
        seq_out.envelope_clock    = tick & (count_inc == SEQ_ENV_COUNT);
        seq_out.extra_length_flag = tick ? ~count_inc[0] : extra_reg;
        seq_out.sample_valid      = power & hit;
    end

    // State moves only on an accepted request with power on.
    always_comb begin
        prev_div_next = prev_div_reg;
        count_next    = count_reg;
        extra_next    = extra_reg;
        acc_next      = acc_reg;
        if (step && power) begin
            prev_div_next = div_bit;
            acc_next      = hit ? (acc_sum - THRESH) : acc_sum;
            if (tick) begin
                count_next = count_inc;
                extra_next = ~count_inc[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= RATE_RESET;
            prev_div_reg    <= 1'b0;
            count_reg       <= '0;
            extra_reg       <= 1'b0;
            acc_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                sample_rate_reg <= cfg_wr_data;
            end
            prev_div_reg <= prev_div_next;
            count_reg    <= count_next;
            extra_reg    <= extra_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

@@ design/afsm_mix_lane.sv @@
// One stereo side of the mixer: routing sum, DAC offset and master volume.
module afsm_mix_lane import afsm_pkg::*; (
    input  logic [NUM_CH-1:0][AMP_W-1:0] amp,
    input  logic [NUM_CH-1:0]            route,
    input  logic [VOL_W-1:0]             vol,
    output logic signed [SAMPLE_W-1:0]   sample
);

    logic [5:0]         sum;
    logic signed [7:0]  diff;
    logic signed [12:0] prod;

    // Sum the amplitudes routed to this side, then scale the offset value.
    always_comb begin
        sum = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (route[i]) begin
                sum = sum + 6'(amp[i]);
            end
        end
        diff   = $signed({1'b0, sum, 1'b0}) - MIX_OFFSET;
        prod   = diff * $signed({1'b0, 4'(vol) + 4'd1});
        sample = prod[SAMPLE_W-1:0];
    end

endmodule

@@ design/apu_frame_sequencer_mixer.sv @@
// Top level: frame sequencer and stereo mixer with a stream interface.
//
// One input request per machine clock tick arrives on the s_ channel; each
// carries the divider byte, the power bit, four channel amplitudes, channel
// enables, panning and master volume. Every request yields exactly one result
// on the m_ channel: length, sweep and envelope strobes, the extra-length
// flag, a sample flag and left and right samples as numerators over 480.
// The sample rate register is written through cfg_wr_en and cfg_wr_data.
// Each result is registered in the output buffer before it shows on m_tvalid; one
// request can be accepted every cycle while s_tready is high. Sequencer, accumulator
// and both mixer lanes finish within the accept cycle; the result lands in a two-entry
// output buffer. When the receiver stalls, the second entry absorbs one more
// request and s_tready then drops until that entry moves to the main register.
// Synchronous reset clears the sequencer, accumulator and buffer, and sets the
// sample rate to 44100 Hz. With power off a request changes no state and
// returns zero strobes and samples along with the held extra-length flag.
module apu_frame_sequencer_mixer import afsm_pkg::*; #(
    parameter int unsigned CLOCK_HZ = DEFAULT_CLOCK_HZ
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [RATE_W-1:0]    cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // div_value[7:0], power_on[8], amp_ch1[12:9], amp_ch2[16:13], amp_ch3[20:17],
    // amp_ch4[24:21], channel_enables[28:25], panning[36:29], master_volume[44:37]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // length_clock[0], sweep_clock[1], envelope_clock[2], extra_length_flag[3],
    // sample_valid[4], left_sample[14:5], right_sample[24:15]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [7:0]                   div_value;
    logic                         power_on;
    logic [NUM_CH-1:0][AMP_W-1:0] amp_raw;
    logic [NUM_CH-1:0][AMP_W-1:0] amp_gated;
    logic [NUM_CH-1:0]            channel_enables;
    logic [7:0]                   panning;
    logic [7:0]                   master_volume;

    logic                         accept;
    seq_out_t                     seq_out;
    logic signed [SAMPLE_W-1:0]   left_mix;
    logic signed [SAMPLE_W-1:0]   right_mix;
    result_t                      result;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    // Unpack the input request.
    always_comb begin
        div_value       = s_tdata[7:0];
        power_on        = s_tdata[8];
        amp_raw[0]      = s_tdata[12:9];
        amp_raw[1]      = s_tdata[16:13];
        amp_raw[2]      = s_tdata[20:17];
        amp_raw[3]      = s_tdata[24:21];
        channel_enables = s_tdata[28:25];
        panning         = s_tdata[36:29];
        master_volume   = s_tdata[44:37];
        for (int i = 0; i < NUM_CH; i++) begin
            amp_gated[i] = channel_enables[i] ? amp_raw[i] : '0;
        end
    end

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;

    afsm_seq #(
        .CLOCK_HZ(CLOCK_HZ)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .step       (accept),
        .div_bit    (div_value[4]),
        .power      (power_on),
        .seq_out    (seq_out)
    );

    // Two mixer lanes, one per stereo side.
    afsm_mix_lane u_lane_left (
        .amp   (amp_gated),
        .route (panning[7:4]),
        .vol   (master_volume[6:4]),
        .sample(left_mix)
    );

    afsm_mix_lane u_lane_right (
        .amp   (amp_gated),
        .route (panning[3:0]),
        .vol   (master_volume[2:0]),
        .sample(right_mix)
    );

    // Merge lanes and sequencer; samples read zero unless one is produced.
    always_comb begin
        result.pad          = '0;
        result.seq          = seq_out;
        result.left_sample  = seq_out.sample_valid ? left_mix : '0;
        result.right_sample = seq_out.sample_valid ? right_mix : '0;
    end

    // Two-entry output buffer: main register plus a skid entry.
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = result;
                main_valid_next = accept;
            end
        end else if (accept) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg;

    // The skid entry is only filled behind a full main register.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while main register empty");

    // Without a sample both sample fields are zero.
    a_no_sample_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !main_reg.seq.sample_valid) |->
        (main_reg.left_sample == '0 && main_reg.right_sample == '0))
        else $error("sample fields nonzero without sample_valid");

    // The envelope step falls on an odd count, apart from length and sweep.
    a_env_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && main_reg.seq.envelope_clock) |->
        (!main_reg.seq.length_clock && !main_reg.seq.sweep_clock &&
         !main_reg.seq.extra_length_flag))
        else $error("envelope strobe together with an even-count strobe");

    // A sweep step is always on an even count, so length fires with it.
    a_sweep_with_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && main_reg.seq.sweep_clock) |->
        (main_reg.seq.length_clock && main_reg.seq.extra_length_flag))
        else $error("sweep strobe without length strobe");

endmodule

@@ tb/apu_frame_sequencer_mixer_test.sv @@
// Self-checking testbench for the frame sequencer and stereo mixer.
`timescale 1ns / 1ps

module apu_frame_sequencer_mixer_test import afsm_pkg::*;;

    localparam int unsigned CLOCK_HZ = DEFAULT_CLOCK_HZ;

    // One tick request as it travels on s_tdata, lowest field last.
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] master_volume;
        logic [7:0] panning;
        logic [3:0] channel_enables;
        logic [3:0] amp_ch4;
        logic [3:0] amp_ch3;
        logic [3:0] amp_ch2;
        logic [3:0] amp_ch1;
        logic       power_on;
        logic [7:0] div_value;
    } tick_req_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [RATE_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    apu_frame_sequencer_mixer #(.CLOCK_HZ(CLOCK_HZ)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Stimulus and expectation stores.
    tick_req_t pending_ticks[$];
    result_t   mix_results_due[$];

    // Predictor state: sample rate register, sequencer and rate accumulator.
    logic [RATE_W-1:0] rate_reg;
    logic              seq_div_bit;
    logic [SEQ_W-1:0]  seq_count;
    logic              extra_len;
    int unsigned       rate_acc;

    int  mismatches  = 0;
    int  ticks_queued = 0;
    bit  idle_on     = 1'b1;
    bit  req_taken   = 1'b0;
    int  send_gap    = 0;
    int  hold_gap    = 0;

    // Divider stimulus: bit 4 toggles after short random runs.
    logic div_level = 1'b0;
    int   div_run   = 0;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Gap lengths: mostly none, often short, sometimes long.
    function automatic int pick_gap(bit on);
        int r;
        if (!on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // One side of the mixer: (2*S - 60) * (v + 1) as a 10-bit value.
    function automatic logic [SAMPLE_W-1:0] mix_lane(input logic [3:0] g1, input logic [3:0] g2,
                                                     input logic [3:0] g3, input logic [3:0] g4,
                                                     input logic [3:0] route,
                                                     input logic [VOL_W-1:0] vol);
        int lvl_sum;
        int val;
        lvl_sum = 0;
        if (route[0]) lvl_sum += g1;
        if (route[1]) lvl_sum += g2;
        if (route[2]) lvl_sum += g3;
        if (route[3]) lvl_sum += g4;
        val = (2 * lvl_sum - int'(MIX_OFFSET)) * (int'(vol) + 1);
        return val[SAMPLE_W-1:0];
    endfunction

    // Advances the predicted sequencer and accumulator for one tick.
    task automatic step_sequencer_mixer(input tick_req_t r, output result_t res);
        logic [3:0] g1, g2, g3, g4;
        res = '0;
        if (r.power_on) begin
            if (seq_div_bit && !r.div_value[4]) begin
                seq_count = seq_count + 1'b1;
                res.seq.envelope_clock = (seq_count == SEQ_ENV_COUNT);
                res.seq.sweep_clock    = (seq_count[1:0] == SEQ_SWEEP_PHASE);
                res.seq.length_clock   = !seq_count[0];
                extra_len              = !seq_count[0];
            end
            seq_div_bit = r.div_value[4];

            rate_acc += rate_reg;
            if (rate_acc >= CLOCK_HZ) begin
                rate_acc -= CLOCK_HZ;
                res.seq.sample_valid = 1'b1;
                g1 = r.channel_enables[0] ? r.amp_ch1 : 4'd0;
                g2 = r.channel_enables[1] ? r.amp_ch2 : 4'd0;
                g3 = r.channel_enables[2] ? r.amp_ch3 : 4'd0;
                g4 = r.channel_enables[3] ? r.amp_ch4 : 4'd0;
                res.left_sample  = mix_lane(g1, g2, g3, g4, r.panning[7:4],
                                            r.master_volume[6:4]);
                res.right_sample = mix_lane(g1, g2, g3, g4, r.panning[3:0],
                                            r.master_volume[2:0]);
            end
        end
        res.seq.extra_length_flag = extra_len;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Mixer fields: full scale, silence, or random.
    task automatic fill_mixer(inout tick_req_t r);
        case ($urandom_range(0, 7))
            0: begin
                {r.amp_ch1, r.amp_ch2, r.amp_ch3, r.amp_ch4} = 16'hFFFF;
                r.channel_enables = 4'hF;
                r.panning         = 8'hFF;
                r.master_volume   = 8'hFF;
            end
            1: begin
                {r.amp_ch1, r.amp_ch2, r.amp_ch3, r.amp_ch4} = 16'h0000;
                r.channel_enables = 4'hF;
                r.panning         = 8'hFF;
                r.master_volume   = 8'h77;
            end
            default: begin
                {r.amp_ch1, r.amp_ch2, r.amp_ch3, r.amp_ch4} = 16'($urandom);
                r.channel_enables = 4'($urandom);
                r.panning         = 8'($urandom);
                r.master_volume   = 8'($urandom);
            end
        endcase
    endtask

    // Random tick: divider runs with a little noise, power mostly on.
    task automatic queue_random_tick();
        tick_req_t r;
        r = '0;
        fill_mixer(r);
        r.power_on = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 9) == 0) begin
            r.div_value = 8'($urandom);
        end else begin
            if (div_run == 0) begin
                div_level = ~div_level;
                div_run   = $urandom_range(1, 4);
            end
            div_run--;
            r.div_value    = 8'($urandom);
            r.div_value[4] = div_level;
        end
        pending_ticks.push_back(r);
        ticks_queued++;
    endtask

    task automatic queue_tick(input logic power, input logic [7:0] div, input bit loud);
        tick_req_t r;
        r = '0;
        r.power_on  = power;
        r.div_value = div;
        {r.amp_ch1, r.amp_ch2, r.amp_ch3, r.amp_ch4} = loud ? 16'hFFFF : 16'h0000;
        r.channel_enables = 4'hF;
        r.panning         = loud ? 8'hFF : 8'h00;
        r.master_volume   = loud ? 8'hFF : 8'h00;
        pending_ticks.push_back(r);
        ticks_queued++;
    endtask

    // Waits until every request went out and every result came back.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_tvalid || mix_results_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = rate;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Request driver: presents queued ticks with random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (req_taken) begin
                send_gap = pick_gap(idle_on);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                s_tdata  <= pending_ticks.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_gap > 0) begin
            hold_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            hold_gap = pick_gap(idle_on);
        end
    end

    // Monitor: checks results, then predicts for the request taken at this edge.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t pred;
        if (!aresetn) begin
            rate_reg    = RATE_RESET;
            seq_div_bit = 1'b0;
            seq_count   = '0;
            extra_len   = 1'b0;
            rate_acc    = 0;
            mix_results_due.delete();
            req_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (mix_results_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = mix_results_due.pop_front();
                    check_field("length_clock", want.seq.length_clock, got.seq.length_clock);
                    check_field("sweep_clock", want.seq.sweep_clock, got.seq.sweep_clock);
                    check_field("envelope_clock", want.seq.envelope_clock,
                                got.seq.envelope_clock);
                    check_field("extra_length_flag", want.seq.extra_length_flag,
                                got.seq.extra_length_flag);
                    check_field("sample_valid", want.seq.sample_valid, got.seq.sample_valid);
                    check_field("left_sample", $signed(want.left_sample),
                                $signed(got.left_sample));
                    check_field("right_sample", $signed(want.right_sample),
                                $signed(got.right_sample));
                end
            end
            if (s_tvalid && s_tready) begin
                step_sequencer_mixer(tick_req_t'(s_tdata), pred);
                mix_results_due.push_back(pred);
            end
            if (cfg_wr_en) begin
                rate_reg = cfg_wr_data;
            end
            req_taken <= s_tvalid && s_tready;
        end
    end

    // Main sequence: reset, directed ticks, then phases at various sample rates.
    initial begin
        int phase;
        int n;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Power off holds everything, including the divider bit history.
        queue_tick(1'b0, 8'hFF, 1'b1);
        queue_tick(1'b0, 8'h00, 1'b0);
        queue_tick(1'b1, 8'hFF, 1'b1);
        queue_tick(1'b0, 8'h00, 1'b0);
        // The held high bit falls here once power is back.
        queue_tick(1'b1, 8'h00, 1'b1);
        // Alternating levels of divider bit 4 give falling edges that walk the sequencer through a full wrap.
        for (int k = 0; k < 16; k++) begin
            queue_tick(1'b1, (k % 2 == 0) ? 8'h10 : 8'hEF, k % 4 < 2);
        end
        wait_drained();

        phase = 0;
        while (ticks_queued < 650 && phase < 60) begin
            case (phase)
                0: write_rate(RATE_W'(96000));
                1: write_rate(RATE_W'(8000));
                2: write_rate('0);
                3: write_rate({RATE_W{1'b1}});
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        write_rate(RATE_W'($urandom_range(8000, 96000)));
                    end else begin
                        write_rate(RATE_W'($urandom_range(96000, 131071)));
                    end
                end
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(80, 120);
            repeat (n) queue_random_tick();
            wait_drained();
            phase++;
        end

        repeat (5) @(negedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/afsm_pkg.sv
design/afsm_seq.sv
design/afsm_mix_lane.sv
design/apu_frame_sequencer_mixer.sv
tb/apu_frame_sequencer_mixer_test.sv
